[hdl/delimited_frame_checksum_parser_core_assert.svh]
// assertion macros for the frame parser modules
// expects signals clk and rst_n in the including module
`ifndef DELIMITED_FRAME_CHECKSUM_PARSER_CORE_ASSERT_SVH
`define DELIMITED_FRAME_CHECKSUM_PARSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DFCP_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("frame parser assertion failed");
`define DFCP_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("frame parser assertion failed");
`else
`define DFCP_ASSERT_IMP(lbl, a, c)
`define DFCP_ASSERT_NXT(lbl, a, c)
`endif
`endif

[hdl/dfcp_pkg.sv]
// shared types and constants of the delimited frame checksum parser
// no dependencies
`timescale 1ns / 1ps
package dfcp_pkg;
  localparam int MAX_DATA_BYTES = 12;
  localparam int DATA_IDX_W     = $clog2(MAX_DATA_BYTES);
  localparam int COUNT_W        = 4;
  localparam int BC_W           = $clog2(MAX_DATA_BYTES + 5);
  localparam int CFG_IDX_W      = 1;
  localparam int Q_DEPTH        = 2;
  localparam int Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);
  localparam logic [7:0] START_RESET = 8'd42;
  localparam logic [7:0] END_RESET   = 8'd35;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE = 1'b0,
    REG_END_BYTE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_SHORT   = 2'd2,
    ST_LONG    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]         addr;
    logic [7:0]         cmd;
    logic [COUNT_W-1:0] cnt;
    status_t            status;
  } desc_t;

  typedef struct packed {
    logic                  done;
    logic [DATA_IDX_W-1:0] rd_addr;
  } store_req_t;
endpackage

[hdl/dfcp_front.sv]
// front end: config registers, frame hunt and collect, checksum, data store
// depends on dfcp_pkg
`timescale 1ns / 1ps
module dfcp_front import dfcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 q_push,
  output desc_t                q_desc,
  input  logic                 q_full,
  input  store_req_t           req,
  output logic [7:0]           rd_data
);
  logic [7:0]      start_r, end_r;
  logic            in_frame_r, in_frame_nxt;
  logic [BC_W-1:0] byte_count_r, byte_count_nxt;
  logic [6:0]      sum_r, sum_nxt;
  logic [7:0]      pending_r, pending_nxt;
  logic [7:0]      addr_r, cmd_r;
  logic            busy_r, busy_nxt;
  logic [7:0]      mem [MAX_DATA_BYTES];
  logic [7:0]      rd_data_r;

  logic            accept, is_end, collect, mem_we;
  logic [BC_W-1:0] n_minus3, wr_off;
  logic            too_long, too_short, bad_sum;

  assign in_stall = in_frame_r && (busy_r || q_full);
  assign accept   = in_valid && !in_stall;
  assign is_end   = in_frame_r && (in_rx_byte == end_r);
  assign collect  = accept && in_frame_r && !is_end;
  assign q_push   = accept && is_end;
  assign mem_we   = collect && (byte_count_r >= BC_W'(2))
                    && (byte_count_r <= BC_W'(MAX_DATA_BYTES + 1));
  assign wr_off   = byte_count_r - BC_W'(2);
  assign n_minus3 = byte_count_r - BC_W'(3);
  assign too_long  = byte_count_r > BC_W'(MAX_DATA_BYTES + 3);
  assign too_short = byte_count_r < BC_W'(3);
  assign bad_sum   = pending_r[7] || (sum_r != pending_r[6:0]);
  assign rd_data   = rd_data_r;

  always_comb begin
    q_desc.addr = (byte_count_r >= BC_W'(1)) ? addr_r : 8'd0;
    q_desc.cmd  = (byte_count_r >= BC_W'(2)) ? cmd_r : 8'd0;
    priority if (too_long) begin
      q_desc.status = ST_LONG;
      q_desc.cnt    = '0;
    end else if (too_short) begin
      q_desc.status = ST_SHORT;
      q_desc.cnt    = '0;
    end else if (bad_sum) begin
      q_desc.status = ST_BAD_SUM;
      q_desc.cnt    = n_minus3[COUNT_W-1:0];
    end else begin
      q_desc.status = ST_OK;
      q_desc.cnt    = n_minus3[COUNT_W-1:0];
    end
  end

  always_comb begin
    in_frame_nxt   = in_frame_r;
    byte_count_nxt = byte_count_r;
    sum_nxt        = sum_r;
    pending_nxt    = pending_r;
    busy_nxt       = busy_r;
    if (req.done) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      if (!in_frame_r) begin
        if (in_rx_byte == start_r) begin
          in_frame_nxt   = 1'b1;
          byte_count_nxt = '0;
          sum_nxt        = '0;
          pending_nxt    = '0;
        end
      end else if (!is_end) begin
        if (byte_count_r != '0) begin
          sum_nxt = sum_r + pending_r[6:0];
        end
        pending_nxt = in_rx_byte;
        if (byte_count_r < BC_W'(MAX_DATA_BYTES + 4)) begin
          byte_count_nxt = byte_count_r + BC_W'(1);
        end
      end else begin
        in_frame_nxt   = 1'b0;
        byte_count_nxt = '0;
        sum_nxt        = '0;
        pending_nxt    = '0;
        if (q_desc.status == ST_OK && q_desc.cnt != '0) begin
          busy_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r      <= START_RESET;
      end_r        <= END_RESET;
      in_frame_r   <= 1'b0;
      byte_count_r <= '0;
      sum_r        <= '0;
      pending_r    <= '0;
      busy_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_START_BYTE: start_r <= cfg_wdata;
          REG_END_BYTE:   end_r   <= cfg_wdata;
          default: ;
        endcase
      end
      in_frame_r   <= in_frame_nxt;
      byte_count_r <= byte_count_nxt;
      sum_r        <= sum_nxt;
      pending_r    <= pending_nxt;
      busy_r       <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (collect && byte_count_r == BC_W'(0)) begin
      addr_r <= in_rx_byte;
    end
    if (collect && byte_count_r == BC_W'(1)) begin
      cmd_r <= in_rx_byte;
    end
  end

  // data store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_off[DATA_IDX_W-1:0]] <= in_rx_byte;
    end
    rd_data_r <= mem[req.rd_addr];
  end
endmodule

[hdl/dfcp_queue.sv]
// short descriptor queue between front end and result sequencer
// depends on dfcp_pkg
`timescale 1ns / 1ps
module dfcp_queue import dfcp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);
  desc_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = count_r == Q_CNT_W'(Q_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end
endmodule

[hdl/dfcp_back.sv]
// result sequencer: walks a frame descriptor and drives the output register
// depends on dfcp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "delimited_frame_checksum_parser_core_assert.svh"
module dfcp_back import dfcp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  desc_t              q_head,
  output logic               q_pop,
  output store_req_t         req,
  input  logic [7:0]         rd_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_address,
  output logic [7:0]         out_frame_command,
  output logic [3:0]         out_data_index,
  output logic [7:0]         out_data_byte,
  output logic               out_data_valid,
  output logic [3:0]         out_data_count,
  output logic [1:0]         out_frame_status,
  output logic               out_last
);
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FETCH  = 4'b0010,
    S_LOAD   = 4'b0100,
    S_SINGLE = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  desc_t              desc_r;
  logic [COUNT_W-1:0] k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         addr_r, cmd_r, byte_r;
  logic [3:0]         index_r, count_r;
  logic               dvalid_r, last_r;
  status_t            status_r;
  logic               out_free, load_data, load_single, is_last;

  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = (k_r + COUNT_W'(1)) == desc_r.cnt;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign load_data   = (state_r == S_LOAD) && out_free;
  assign load_single = (state_r == S_SINGLE) && out_free;
  assign req.rd_addr = k_r[DATA_IDX_W-1:0];
  assign req.done    = load_data && is_last;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          k_nxt = '0;
          if (q_head.status == ST_OK && q_head.cnt != '0) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_SINGLE;
          end
        end
      end
      S_FETCH: state_nxt = S_LOAD;
      S_LOAD: begin
        if (out_free) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + COUNT_W'(1);
            state_nxt = S_FETCH;
          end
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_data || load_single) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_head;
    end
    if (load_data || load_single) begin
      addr_r   <= desc_r.addr;
      cmd_r    <= desc_r.cmd;
      count_r  <= desc_r.cnt;
      status_r <= desc_r.status;
      index_r  <= load_data ? k_r : 4'd0;
      byte_r   <= load_data ? rd_data : 8'd0;
      dvalid_r <= load_data;
      last_r   <= load_single || is_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_address = addr_r;
  assign out_frame_command = cmd_r;
  assign out_data_index    = index_r;
  assign out_data_byte     = byte_r;
  assign out_data_valid    = dvalid_r;
  assign out_data_count    = count_r;
  assign out_frame_status  = status_r;
  assign out_last          = last_r;

  `DFCP_ASSERT_IMP(a_data_only_ok, out_valid_r && dvalid_r, status_r == ST_OK)
  `DFCP_ASSERT_IMP(a_nodata_is_last, out_valid_r && !dvalid_r, last_r)
  `DFCP_ASSERT_IMP(a_index_in_count, out_valid_r && dvalid_r, index_r < count_r)
  `DFCP_ASSERT_NXT(a_done_shows_last, req.done, out_valid_r && last_r && dvalid_r)
endmodule

[hdl/delimited_frame_checksum_parser_core.sv]
// top level of the delimited frame checksum parser
// depends on dfcp_pkg, dfcp_front, dfcp_queue, dfcp_back
//
//   port group   direction   handshake            payload
//   in_          input       in_valid / in_stall  in_rx_byte
//   out_         output      out_valid/out_stall  address, command, index, byte, flags
//   cfg_         input       cfg_we               cfg_index, cfg_wdata
//
// the front end takes one word per cycle, while collecting only when not stalled
// a frame with data gives its results one by one, each by a store read then a load
// an error or empty frame gives a single result via the queue and the single state
// while a frame's data is being read out, words after the next start word stall
// reset is synchronous; config is applied in the cycle after cfg_we
`timescale 1ns / 1ps
module delimited_frame_checksum_parser_core import dfcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_frame_address,
  output logic [7:0]           out_frame_command,
  output logic [3:0]           out_data_index,
  output logic [7:0]           out_data_byte,
  output logic                 out_data_valid,
  output logic [3:0]           out_data_count,
  output logic [1:0]           out_frame_status,
  output logic                 out_last
);
  logic       q_push, q_full, q_pop, q_empty;
  desc_t      q_desc, q_head;
  store_req_t req;
  logic [7:0] rd_data;

  dfcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_push     (q_push),
    .q_desc     (q_desc),
    .q_full     (q_full),
    .req        (req),
    .rd_data    (rd_data)
  );

  dfcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  dfcp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .req               (req),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_address (out_frame_address),
    .out_frame_command (out_frame_command),
    .out_data_index    (out_data_index),
    .out_data_byte     (out_data_byte),
    .out_data_valid    (out_data_valid),
    .out_data_count    (out_data_count),
    .out_frame_status  (out_frame_status),
    .out_last          (out_last)
  );
endmodule

[test/frame_sb_pkg.sv]
// scoreboard for the delimited frame checksum parser: predicts the result words
// of each frame from the accepted byte words and checks the block's results
// depends on dfcp_pkg
`timescale 1ns / 1ps
package frame_sb_pkg;
  import dfcp_pkg::*;

  localparam int STORE_DEPTH = MAX_DATA_BYTES + 3;

  typedef struct {
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [3:0] idx;
    logic [7:0] dbyte;
    logic       dvalid;
    logic [3:0] cnt;
    status_t    status;
    logic       last;
  } frame_result_t;

  class frame_scoreboard;
    logic [7:0]    start_byte;
    logic [7:0]    end_byte;
    logic          in_frame;
    logic [4:0]    byte_count;
    logic [7:0]    frame_store [STORE_DEPTH];
    logic [6:0]    running_sum;
    logic [7:0]    pending_byte;
    frame_result_t expected_results [$];
    int            fail_count;

    function new();
      start_byte = START_RESET;
      end_byte   = END_RESET;
      foreach (frame_store[i]) frame_store[i] = 8'h00;
      fail_count = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      in_frame     = 1'b0;
      byte_count   = '0;
      running_sum  = '0;
      pending_byte = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [7:0] value);
      if (idx == REG_START_BYTE) start_byte = value;
      else end_byte = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void push_result(logic [7:0] addr, logic [7:0] cmd, logic [3:0] idx,
                              logic [7:0] dbyte, logic dvalid, logic [3:0] cnt,
                              status_t status, logic last);
      frame_result_t r;
      r.addr   = addr;
      r.cmd    = cmd;
      r.idx    = idx;
      r.dbyte  = dbyte;
      r.dvalid = dvalid;
      r.cnt    = cnt;
      r.status = status;
      r.last   = last;
      expected_results.push_back(r);
    endfunction

    // called for every accepted input word
    function void note_byte(logic [7:0] b);
      logic [7:0] addr;
      logic [7:0] cmd;
      int         n;
      int         dcnt;
      if (!in_frame) begin
        if (b == start_byte) begin
          clear_frame();
          in_frame = 1'b1;
        end
        return;
      end
      if (b != end_byte) begin
        if (byte_count > 0) running_sum = running_sum + pending_byte[6:0];
        pending_byte = b;
        if (byte_count < STORE_DEPTH) frame_store[byte_count] = b;
        if (byte_count < STORE_DEPTH + 1) byte_count = byte_count + 5'd1;
        return;
      end
      n    = byte_count;
      addr = (n >= 1) ? frame_store[0] : 8'h00;
      cmd  = (n >= 2) ? frame_store[1] : 8'h00;
      if (n > STORE_DEPTH) begin
        push_result(addr, cmd, 4'd0, 8'h00, 1'b0, 4'd0, ST_LONG, 1'b1);
      end else if (n < 3) begin
        push_result(addr, cmd, 4'd0, 8'h00, 1'b0, 4'd0, ST_SHORT, 1'b1);
      end else begin
        dcnt = n - 3;
        if (pending_byte[7] || pending_byte[6:0] != running_sum) begin
          push_result(addr, cmd, 4'd0, 8'h00, 1'b0, 4'(dcnt), ST_BAD_SUM, 1'b1);
        end else if (dcnt == 0) begin
          push_result(addr, cmd, 4'd0, 8'h00, 1'b0, 4'd0, ST_OK, 1'b1);
        end else begin
          for (int k = 0; k < dcnt; k++) begin
            push_result(addr, cmd, 4'(k), frame_store[2 + k], 1'b1, 4'(dcnt), ST_OK,
                        (k + 1 == dcnt));
          end
        end
      end
      clear_frame();
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    // called for every accepted result word
    function void check_result(logic [7:0] addr, logic [7:0] cmd, logic [3:0] idx,
                               logic [7:0] dbyte, logic dvalid, logic [3:0] cnt,
                               logic [1:0] status, logic last);
      frame_result_t e;
      if (expected_results.size() == 0) begin
        $error("result word with no expected result: address %0d command %0d", addr, cmd);
        fail_count++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("frame_address", e.addr, addr);
      compare_field("frame_command", e.cmd, cmd);
      compare_field("data_index", e.idx, idx);
      compare_field("data_byte", e.dbyte, dbyte);
      compare_field("data_valid", e.dvalid, dvalid);
      compare_field("data_count", e.cnt, cnt);
      compare_field("frame_status", e.status, status);
      compare_field("last", e.last, last);
    endfunction
  endclass
endpackage

[test/tb_top.sv]
// top of the frame parser testbench: clock, reset, byte word driver and
// result monitor around the block; depends on dfcp_pkg and frame_sb_pkg
`timescale 1ns / 1ps
module tb_top;
  import dfcp_pkg::*;
  import frame_sb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {
    FL_NONE,
    FL_BAD_SUM,
    FL_TOP_BIT,
    FL_SHORT
  } flaw_t;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_START_BYTE;
  logic [7:0]           cfg_wdata   = 8'h00;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte  = 8'h00;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [7:0]           out_frame_address;
  logic [7:0]           out_frame_command;
  logic [3:0]           out_data_index;
  logic [7:0]           out_data_byte;
  logic                 out_data_valid;
  logic [3:0]           out_data_count;
  logic [1:0]           out_frame_status;
  logic                 out_last;

  frame_scoreboard sb = new();

  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         bytes_sent    = 0;
  int         cycle_count   = 0;
  logic [7:0] cur_start     = START_RESET;
  logic [7:0] cur_end       = END_RESET;

  delimited_frame_checksum_parser_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_address (out_frame_address),
    .out_frame_command (out_frame_command),
    .out_data_index    (out_data_index),
    .out_data_byte     (out_data_byte),
    .out_data_valid    (out_data_valid),
    .out_data_count    (out_data_count),
    .out_frame_status  (out_frame_status),
    .out_last          (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        sb.check_result(out_frame_address, out_frame_command, out_data_index,
                        out_data_byte, out_data_valid, out_data_count,
                        out_frame_status, out_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic stop_stream();
    in_valid <= 1'b0;
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == cur_end);
    return b;
  endfunction

  task automatic send_frame(input int ndata, input flaw_t flaw);
    logic [7:0] b;
    logic [6:0] sum;
    logic [7:0] cks;
    sum = '0;
    send_byte(cur_start);
    if (flaw == FL_SHORT) begin
      repeat ($urandom_range(2)) send_byte(body_byte());
      send_byte(cur_end);
      return;
    end
    repeat (ndata + 2) begin
      b = body_byte();
      sum = sum + b[6:0];
      send_byte(b);
    end
    case (flaw)
      FL_BAD_SUM: cks = {1'b0, sum + 7'(1 + $urandom_range(126))};
      FL_TOP_BIT: cks = {1'b1, sum};
      default:    cks = {1'b0, sum};
    endcase
    send_byte(cks);
    send_byte(cur_end);
  endtask

  task automatic write_regs(input logic [7:0] s, input logic [7:0] e);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_BYTE;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_index <= REG_END_BYTE;
    cfg_wdata <= e;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(REG_START_BYTE, s);
    sb.set_reg(REG_END_BYTE, e);
    cur_start = s;
    cur_end   = e;
    repeat (2) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input int min_bytes);
    int first;
    int r;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    first         = bytes_sent;
    while (bytes_sent - first < min_bytes) begin
      if ($urandom_range(3) == 0) begin
        repeat (1 + $urandom_range(2)) send_byte(8'($urandom_range(255)));
      end
      r = $urandom_range(99);
      if (r < 60)      send_frame($urandom_range(MAX_DATA_BYTES), FL_NONE);
      else if (r < 72) send_frame($urandom_range(MAX_DATA_BYTES), FL_BAD_SUM);
      else if (r < 80) send_frame($urandom_range(MAX_DATA_BYTES), FL_TOP_BIT);
      else if (r < 88) send_frame(0, FL_SHORT);
      else if (r < 94) send_frame(MAX_DATA_BYTES + 1 + $urandom_range(3), FL_NONE);
      else             send_frame(MAX_DATA_BYTES, FL_NONE);
    end
    // close with a clean frame so the parser is back to hunting
    send_frame($urandom_range(3), FL_NONE);
    stop_stream();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // noise while hunting, end word included
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_end);
    // empty frame
    send_byte(cur_start);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(cur_end);
    // too short, no bytes and two bytes
    send_byte(cur_start);
    send_byte(cur_end);
    send_byte(cur_start);
    send_byte(8'h05);
    send_byte(8'h06);
    send_byte(cur_end);
    // checksum with top bit set
    send_byte(cur_start);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h83);
    send_byte(cur_end);
    // start word inside a frame
    send_byte(cur_start);
    send_byte(cur_start);
    send_byte(8'h01);
    send_byte(cur_start);
    send_byte({1'b0, 7'(cur_start + 8'h01 + cur_start)});
    send_byte(cur_end);
    send_frame(2, FL_BAD_SUM);
    send_frame(MAX_DATA_BYTES, FL_NONE);
    send_frame(MAX_DATA_BYTES + 1, FL_NONE);
    stop_stream();

    run_phase(0, 0, 5);
    write_regs(8'h00, 8'hFF);
    run_phase(53, 0, 5);
    write_regs(8'hFF, 8'h00);
    run_phase(0, 53, 5);
    write_regs(8'h7E, 8'h7E);
    run_phase(14, 14, 5);

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hdl
hdl/dfcp_pkg.sv
hdl/dfcp_front.sv
hdl/dfcp_queue.sv
hdl/dfcp_back.sv
hdl/delimited_frame_checksum_parser_core.sv
test/frame_sb_pkg.sv
test/tb_top.sv
